// ===== hdl/two_axis_stepper_line_mover_assert.svh =====
// shared assertion macros
`ifndef TWO_AXIS_STEPPER_LINE_MOVER_ASSERT_SVH
`define TWO_AXIS_STEPPER_LINE_MOVER_ASSERT_SVH

// same-cycle implication
`define STM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stm assertion failed");

// next-cycle implication
`define STM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stm assertion failed");

`endif

// ===== hdl/stm_pkg.sv =====
package stm_pkg;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    localparam int          PERIOD_SCALE_W = 10;
    localparam logic [9:0]  PERIOD_SCALE   = 10'd1000;
    localparam int          MIN_PERIOD_W   = 16;
    localparam logic [15:0] MIN_PERIOD_RST = 16'd1000;

    localparam logic [3:0] UP_TABLE   [4] = '{4'hA, 4'h6, 4'h5, 4'h9};
    localparam logic [3:0] DOWN_TABLE [4] = '{4'h5, 4'h9, 4'hA, 4'h6};

    typedef enum logic [3:0] {
        DP_NONE, DP_LOAD, DP_ZERO, DP_SQ, DP_SUM, DP_ROOT, DP_DINIT, DP_DIV,
        DP_DSTORE, DP_FIX, DP_NOSCALE, DP_MINIT, DP_MUL, DP_MSTORE, DP_FINISH, DP_TICK
    } t_dp_op;

    typedef enum logic [1:0] {
        PASS_PX, PASS_PY, PASS_CX, PASS_CY
    } t_pass;

    typedef struct packed {
        t_dp_op op;
        t_pass  pass;
        logic   msel_y;
        logic   emit;
        logic   rejected;
    } t_cmd;

    typedef struct packed {
        logic zero_dist;
        logic need_scale;
        logic last;
        logic moving;
    } t_sts;

endpackage

// ===== hdl/stm_move_if.sv =====
interface stm_move_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] target_x;
    logic [15:0] target_y;

    modport source (output valid, op, target_x, target_y, input ready);
    modport sink   (input valid, op, target_x, target_y, output ready);
endinterface

// ===== hdl/stm_res_if.sv =====
interface stm_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  x_coils;
    logic [3:0]  y_coils;
    logic [15:0] x_position;
    logic [15:0] y_position;
    logic        busy_res;
    logic        rejected;

    modport source (output valid, x_coils, y_coils, x_position, y_position, busy_res,
                    rejected, input ready);
    modport sink   (input valid, x_coils, y_coils, x_position, y_position, busy_res,
                    rejected, output ready);
endinterface

// ===== hdl/stm_cfg_if.sv =====
interface stm_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/two_axis_stepper_line_mover.sv =====
// tick or rejected move: result beat registered at the accepting edge, one item per cycle
//   while the result side is ready; move: load, square, sum, root, x and y divides, fix,
//   check, then the beat, with two more divides and two shift-add multiplies before it when
//   scaled up to the minimum period; a move to the current spot gives its beat in the cycle
//   after acceptance; no new item is taken while a move is set up
// synchronous active-low reset: positions, goals, periods zero, coils low, idle, min_period 1000
module two_axis_stepper_line_mover #(
    parameter int POS_WIDTH = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stm_move_if.sink  i_move,
    stm_res_if.source o_res,
    stm_cfg_if.sink   i_cfg
);
    import stm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    stm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_move.valid),
        .i_in_op     (i_move.op),
        .o_in_ready  (i_move.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    stm_dp #(
        .POS_WIDTH (POS_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_target_x   (i_move.target_x),
        .i_target_y   (i_move.target_y),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_data   (i_cfg.data),
        .o_x_coils    (o_res.x_coils),
        .o_y_coils    (o_res.y_coils),
        .o_x_position (o_res.x_position),
        .o_y_position (o_res.y_position),
        .o_busy_res   (o_res.busy_res),
        .o_rejected   (o_res.rejected)
    );
endmodule

// ===== hdl/stm_dp.sv =====
module stm_dp #(
    parameter int POS_WIDTH = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stm_pkg::t_cmd     i_cmd,
    output stm_pkg::t_sts     o_sts,
    input  logic [15:0]       i_target_x,
    input  logic [15:0]       i_target_y,
    input  logic              i_cfg_valid,
    input  logic [15:0]       i_cfg_data,
    output logic [3:0]        o_x_coils,
    output logic [3:0]        o_y_coils,
    output logic [15:0]       o_x_position,
    output logic [15:0]       o_y_position,
    output logic              o_busy_res,
    output logic              o_rejected
);
    import stm_pkg::*;

    localparam int PW   = POS_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int DW   = PW + 1;
    localparam int MW   = 2 * PW + 2;
    localparam int LW   = PW + 1 + F;
    localparam int RRW  = LW + 2;
    localparam int NUMW = PW + PERIOD_SCALE_W;
    localparam int DIVW = NUMW + 2 * F;
    localparam int PXW  = F + PERIOD_SCALE_W;
    localparam int VW   = (LW > PXW) ? LW : PXW;
    localparam int DRW  = VW + 1;
    localparam int MINW = MIN_PERIOD_W + F;
    localparam int NW   = MINW + 1;
    localparam int MACC = F + 32;
    localparam int CW   = $clog2(DIVW + 1);

    logic [15:0]      r_min_period;
    logic [PW-1:0]    r_pos_x, r_pos_y, r_gx, r_gy, n_pos_x, n_pos_y, n_gx, n_gy;
    logic [DW-1:0]    r_ax, r_ay, n_ax, n_ay;
    logic [MW-1:0]    r_sqx, r_sqy, r_mshift, n_sqx, n_sqy, n_mshift;
    logic [NUMW-1:0]  r_numx, r_numy, n_numx, n_numy;
    logic [LW-1:0]    r_root, n_root;
    logic [RRW-1:0]   r_rrem, n_rrem;
    logic [DIVW-1:0]  r_dq, n_dq;
    logic [DRW-1:0]   r_drem, n_drem;
    logic [VW-1:0]    r_dvs, n_dvs;
    logic [PXW-1:0]   r_px, r_py, n_px, n_py;
    logic [NW-1:0]    r_nx, r_ny, n_nx, n_ny, r_mn, n_mn;
    logic [MACC-1:0]  r_mc, r_macc, n_mc, n_macc;
    logic [31:0]      r_per_x, r_per_y, r_el_x, r_el_y;
    logic [31:0]      n_per_x, n_per_y, n_el_x, n_el_y;
    logic [7:0]       r_coil, n_coil;
    logic             r_moving, n_moving;
    logic [CW-1:0]    r_cnt, n_cnt;

    logic signed [DW-1:0] dx, dy;
    logic [RRW-1:0]   rem_t, trial;
    logic [DRW-1:0]   div_t;
    logic [MINW-1:0]  min_fx;
    logic [NW-1:0]    n_big, n_sel;
    logic [31:0]      ex1, ey1;
    logic             step_x, step_y;

    assign min_fx = {r_min_period, {F{1'b0}}};
    assign n_big  = (r_nx > r_ny) ? r_nx : r_ny;
    assign n_sel  = (n_big < NW'(2)) ? NW'(2) : n_big;

    assign o_sts.zero_dist  = (r_ax == '0) && (r_ay == '0);
    assign o_sts.need_scale = (MINW'(r_px) < min_fx) || (MINW'(r_py) < min_fx);
    assign o_sts.last       = (r_cnt == CW'(1));
    assign o_sts.moving     = r_moving;

    always_comb begin
        n_pos_x = r_pos_x;  n_pos_y = r_pos_y;  n_gx = r_gx;  n_gy = r_gy;
        n_ax = r_ax;  n_ay = r_ay;  n_sqx = r_sqx;  n_sqy = r_sqy;
        n_mshift = r_mshift;  n_numx = r_numx;  n_numy = r_numy;
        n_root = r_root;  n_rrem = r_rrem;  n_dq = r_dq;  n_drem = r_drem;
        n_dvs = r_dvs;  n_px = r_px;  n_py = r_py;  n_nx = r_nx;  n_ny = r_ny;
        n_mn = r_mn;  n_mc = r_mc;  n_macc = r_macc;
        n_per_x = r_per_x;  n_per_y = r_per_y;  n_el_x = r_el_x;  n_el_y = r_el_y;
        n_coil = r_coil;  n_moving = r_moving;  n_cnt = r_cnt;

        dx     = '0;
        dy     = '0;
        rem_t  = {r_rrem[RRW-3:0], r_mshift[MW-1:MW-2]};
        trial  = {r_root, 2'b01};
        div_t  = {r_drem[DRW-2:0], r_dq[DIVW-1]};
        ex1    = (r_el_x == '1) ? r_el_x : r_el_x + 32'd1;
        ey1    = (r_el_y == '1) ? r_el_y : r_el_y + 32'd1;
        step_x = (r_pos_x != r_gx) && (ex1 >= r_per_x);
        step_y = (r_pos_y != r_gy) && (ey1 >= r_per_y);

        case (i_cmd.op)
            DP_LOAD: begin
                n_gx = PW'($signed(i_target_x));
                n_gy = PW'($signed(i_target_y));
                dx   = DW'($signed(n_gx)) - DW'($signed(r_pos_x));
                dy   = DW'($signed(n_gy)) - DW'($signed(r_pos_y));
                n_ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
                n_ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
                n_el_x = '0;
                n_el_y = '0;
            end
            DP_ZERO: begin
                n_per_x = '0;
                n_per_y = '0;
            end
            DP_SQ: begin
                n_sqx  = MW'(r_ax) * MW'(r_ax);
                n_sqy  = MW'(r_ay) * MW'(r_ay);
                n_numx = NUMW'(r_ay) * NUMW'(PERIOD_SCALE);
                n_numy = NUMW'(r_ax) * NUMW'(PERIOD_SCALE);
            end
            DP_SUM: begin
                n_mshift = r_sqx + r_sqy;
                n_root   = '0;
                n_rrem   = '0;
                n_cnt    = CW'(LW);
            end
            DP_ROOT: begin
                // one result bit per cycle, two radicand bits shifted in
                n_mshift = {r_mshift[MW-3:0], 2'b00};
                n_cnt    = r_cnt - CW'(1);
                if (rem_t >= trial) begin
                    n_rrem = rem_t - trial;
                    n_root = {r_root[LW-2:0], 1'b1};
                end else begin
                    n_rrem = rem_t;
                    n_root = {r_root[LW-2:0], 1'b0};
                end
            end
            DP_DINIT: begin
                n_drem = '0;
                n_cnt  = CW'(DIVW);
                case (i_cmd.pass)
                    PASS_PX: begin
                        n_dq  = {r_numx, {(2*F){1'b0}}};
                        n_dvs = VW'(r_root);
                    end
                    PASS_PY: begin
                        n_dq  = {r_numy, {(2*F){1'b0}}};
                        n_dvs = VW'(r_root);
                    end
                    PASS_CX: begin
                        n_dq  = DIVW'(min_fx);
                        n_dvs = VW'(r_px);
                    end
                    default: begin
                        n_dq  = DIVW'(min_fx);
                        n_dvs = VW'(r_py);
                    end
                endcase
            end
            DP_DIV: begin
                n_cnt = r_cnt - CW'(1);
                if (div_t >= {1'b0, r_dvs}) begin
                    n_drem = div_t - {1'b0, r_dvs};
                    n_dq   = {r_dq[DIVW-2:0], 1'b1};
                end else begin
                    n_drem = div_t;
                    n_dq   = {r_dq[DIVW-2:0], 1'b0};
                end
            end
            DP_DSTORE: begin
                case (i_cmd.pass)
                    PASS_PX: n_px = PXW'(r_dq);
                    PASS_PY: n_py = PXW'(r_dq);
                    PASS_CX: n_nx = NW'(r_dq) + NW'(r_drem != '0);
                    default: n_ny = NW'(r_dq) + NW'(r_drem != '0);
                endcase
            end
            DP_FIX: begin
                if ((r_px == '0) || (r_py == '0)) begin
                    n_px = r_px + (PXW'(1) << F);
                    n_py = r_py + (PXW'(1) << F);
                end
            end
            DP_NOSCALE: begin
                n_per_x  = 32'(r_px[PXW-1:F]);
                n_per_y  = 32'(r_py[PXW-1:F]);
                n_moving = 1'b1;
            end
            DP_MINIT: begin
                n_mc   = i_cmd.msel_y ? MACC'(r_py) : MACC'(r_px);
                n_mn   = n_sel;
                n_macc = '0;
                n_cnt  = CW'(NW);
            end
            DP_MUL: begin
                // shift-add, low bit of the multiplier first
                n_cnt  = r_cnt - CW'(1);
                n_macc = r_mn[0] ? r_macc + r_mc : r_macc;
                n_mc   = {r_mc[MACC-2:0], 1'b0};
                n_mn   = {1'b0, r_mn[NW-1:1]};
            end
            DP_MSTORE: begin
                if (i_cmd.msel_y) begin
                    n_per_y = r_macc[MACC-1:F];
                end else begin
                    n_per_x = r_macc[MACC-1:F];
                end
            end
            DP_FINISH: begin
                n_moving = 1'b1;
            end
            DP_TICK: begin
                if (r_moving) begin
                    n_el_x = step_x ? '0 : ex1;
                    n_el_y = step_y ? '0 : ey1;
                    if (step_x) begin
                        if ($signed(r_gx) > $signed(r_pos_x)) begin
                            n_coil[7:4] = UP_TABLE[r_pos_x[1:0]];
                            n_pos_x     = r_pos_x + PW'(1);
                        end else begin
                            n_coil[7:4] = DOWN_TABLE[r_pos_x[1:0]];
                            n_pos_x     = r_pos_x - PW'(1);
                        end
                    end
                    if (step_y) begin
                        if ($signed(r_gy) > $signed(r_pos_y)) begin
                            n_coil[3:0] = UP_TABLE[r_pos_y[1:0]];
                            n_pos_y     = r_pos_y + PW'(1);
                        end else begin
                            n_coil[3:0] = DOWN_TABLE[r_pos_y[1:0]];
                            n_pos_y     = r_pos_y - PW'(1);
                        end
                    end
                    if ((n_pos_x == r_gx) && (n_pos_y == r_gy)) begin
                        n_coil   = '0;
                        n_moving = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_period <= MIN_PERIOD_RST;
            r_pos_x  <= '0;  r_pos_y  <= '0;
            r_gx     <= '0;  r_gy     <= '0;
            r_per_x  <= '0;  r_per_y  <= '0;
            r_el_x   <= '0;  r_el_y   <= '0;
            r_coil   <= '0;
            r_moving <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_min_period <= i_cfg_data;
            end
            r_pos_x  <= n_pos_x;  r_pos_y <= n_pos_y;
            r_gx     <= n_gx;     r_gy    <= n_gy;
            r_per_x  <= n_per_x;  r_per_y <= n_per_y;
            r_el_x   <= n_el_x;   r_el_y  <= n_el_y;
            r_coil   <= n_coil;
            r_moving <= n_moving;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax <= n_ax;  r_ay <= n_ay;  r_sqx <= n_sqx;  r_sqy <= n_sqy;
        r_mshift <= n_mshift;  r_numx <= n_numx;  r_numy <= n_numy;
        r_root <= n_root;  r_rrem <= n_rrem;  r_dq <= n_dq;  r_drem <= n_drem;
        r_dvs <= n_dvs;  r_px <= n_px;  r_py <= n_py;  r_nx <= n_nx;  r_ny <= n_ny;
        r_mn <= n_mn;  r_mc <= n_mc;  r_macc <= n_macc;
    end

    // result beat reflects the state after the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_x_coils    <= n_coil[7:4];
            o_y_coils    <= n_coil[3:0];
            o_x_position <= 16'($signed(n_pos_x));
            o_y_position <= 16'($signed(n_pos_y));
            o_busy_res   <= n_moving;
            o_rejected   <= i_cmd.rejected;
        end
    end
endmodule

// ===== hdl/stm_ctrl.sv =====
`include "two_axis_stepper_line_mover_assert.svh"

module stm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_op,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  stm_pkg::t_sts i_sts,
    output stm_pkg::t_cmd o_cmd
);
    import stm_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_LOAD   = 13'b0000000000010,
        S_SUM    = 13'b0000000000100,
        S_ROOT   = 13'b0000000001000,
        S_DINIT  = 13'b0000000010000,
        S_DIV    = 13'b0000000100000,
        S_DSTORE = 13'b0000001000000,
        S_FIX    = 13'b0000010000000,
        S_CHK    = 13'b0000100000000,
        S_MINIT  = 13'b0001000000000,
        S_MUL    = 13'b0010000000000,
        S_MSTORE = 13'b0100000000000,
        S_FINISH = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    t_pass  r_pass, n_pass;
    logic   r_msel, n_msel;
    logic   r_out_valid;
    logic   accept;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        n_msel  = r_msel;
        o_cmd   = '{op: DP_NONE, pass: r_pass, msel_y: r_msel, emit: 1'b0,
                    rejected: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_op == OP_TICK) begin
                        o_cmd.op   = DP_TICK;
                        o_cmd.emit = 1'b1;
                    end else if (i_sts.moving) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.rejected = 1'b1;
                    end else begin
                        o_cmd.op = DP_LOAD;
                        n_state  = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                if (i_sts.zero_dist) begin
                    o_cmd.op   = DP_ZERO;
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.op = DP_SQ;
                    n_state  = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.op = DP_SUM;
                n_state  = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.op = DP_ROOT;
                if (i_sts.last) begin
                    n_pass  = PASS_PX;
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                o_cmd.op = DP_DINIT;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = DP_DIV;
                if (i_sts.last) begin
                    n_state = S_DSTORE;
                end
            end
            S_DSTORE: begin
                o_cmd.op = DP_DSTORE;
                case (r_pass)
                    PASS_PX: begin
                        n_pass  = PASS_PY;
                        n_state = S_DINIT;
                    end
                    PASS_PY: n_state = S_FIX;
                    PASS_CX: begin
                        n_pass  = PASS_CY;
                        n_state = S_DINIT;
                    end
                    default: begin
                        n_msel  = 1'b0;
                        n_state = S_MINIT;
                    end
                endcase
            end
            S_FIX: begin
                o_cmd.op = DP_FIX;
                n_state  = S_CHK;
            end
            S_CHK: begin
                if (i_sts.need_scale) begin
                    n_pass  = PASS_CX;
                    n_state = S_DINIT;
                end else begin
                    o_cmd.op   = DP_NOSCALE;
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_MINIT: begin
                o_cmd.op = DP_MINIT;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = DP_MUL;
                if (i_sts.last) begin
                    n_state = S_MSTORE;
                end
            end
            S_MSTORE: begin
                o_cmd.op = DP_MSTORE;
                if (r_msel) begin
                    n_state = S_FINISH;
                end else begin
                    n_msel  = 1'b1;
                    n_state = S_MINIT;
                end
            end
            S_FINISH: begin
                o_cmd.op   = DP_FINISH;
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= PASS_PX;
            r_msel      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
            r_msel  <= n_msel;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `STM_ASSERT_NOW(a_emit_slot_free, i_clk, i_rst_n, o_cmd.emit, !r_out_valid || i_out_ready)
    `STM_ASSERT_NOW(a_reject_only_busy, i_clk, i_rst_n, o_cmd.rejected, i_sts.moving)
    `STM_ASSERT_NOW(a_sum_nonzero, i_clk, i_rst_n, r_state == S_SUM, !i_sts.zero_dist)
    `STM_ASSERT_NEXT(a_root_holds, i_clk, i_rst_n, (r_state == S_ROOT) && !i_sts.last,
                     r_state == S_ROOT)
endmodule

// ===== verif/two_axis_stepper_line_mover_test.sv =====
`timescale 1ns / 1ps

module two_axis_stepper_line_mover_test;
    import stm_pkg::*;

    typedef struct {
        logic [3:0]  x_coils;
        logic [3:0]  y_coils;
        logic [15:0] x_position;
        logic [15:0] y_position;
        logic        busy_res;
        logic        rejected;
    } t_motion;

    logic i_clk;
    logic i_rst_n;

    stm_move_if move_bus ();
    stm_res_if  res_bus ();
    stm_cfg_if  cfg_bus ();

    two_axis_stepper_line_mover dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_move  (move_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    // mover state as predicted
    logic [15:0] min_ticks;
    logic [15:0] at_x, at_y, goal_x, goal_y;
    logic [31:0] per_x, per_y, run_x, run_y;
    logic [7:0]  coils;
    logic        in_motion;

    t_motion expected_motion[$];
    int      error_count;
    bit      gaps_on;
    bit      rx_calm;
    int      hold_left;
    int      stall_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #36_000_000;
        $display("two_axis_stepper_line_mover_test failed");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic longint unsigned root_fixed(input longint unsigned m);
        longint unsigned root, rem, pair, trial;
        root = 0;
        rem  = 0;
        for (int i = 0; i < 33; i++) begin
            pair = (i < 17) ? ((m >> (2 * (16 - i))) & 3) : 0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic longint unsigned div_fixed(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned q, r;
        q = num / den;
        r = num % den;
        for (int i = 0; i < 32; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned up_div(input longint unsigned a,
                                               input longint unsigned b);
        return a / b + ((a % b) != 0 ? 1 : 0);
    endfunction

    task automatic plan_move(input logic [15:0] tx, input logic [15:0] ty);
        longint dx, dy;
        longint unsigned ax, ay, span, fx, fy, floor_fx, n, nx, ny;
        dx = longint'($signed(tx)) - longint'($signed(at_x));
        dy = longint'($signed(ty)) - longint'($signed(at_y));
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        goal_x = tx;
        goal_y = ty;
        run_x = 0;
        run_y = 0;
        if (ax == 0 && ay == 0) begin
            per_x = 0;
            per_y = 0;
        end else begin
            span = root_fixed(ax * ax + ay * ay);
            fx = div_fixed(ay * 1000, span);
            fy = div_fixed(ax * 1000, span);
            if (fx == 0 || fy == 0) begin
                fx += 64'd1 << 16;
                fy += 64'd1 << 16;
            end
            floor_fx = longint'(min_ticks) << 16;
            if (fx < floor_fx || fy < floor_fx) begin
                n  = 2;
                nx = up_div(floor_fx, fx);
                ny = up_div(floor_fx, fy);
                if (nx > n) n = nx;
                if (ny > n) n = ny;
                fx *= n;
                fy *= n;
            end
            per_x = fx[47:16];
            per_y = fy[47:16];
            in_motion = 1'b1;
        end
    endtask

    function automatic logic [3:0] coil_pattern(input logic [15:0] pos, input logic [15:0] goal);
        return ($signed(goal) > $signed(pos)) ? UP_TABLE[pos[1:0]] : DOWN_TABLE[pos[1:0]];
    endfunction

    task automatic advance_tick();
        if (in_motion) begin
            if (run_x != 32'hFFFF_FFFF) run_x++;
            if (run_y != 32'hFFFF_FFFF) run_y++;
            if (at_x != goal_x && run_x >= per_x) begin
                coils[7:4] = coil_pattern(at_x, goal_x);
                at_x = ($signed(goal_x) > $signed(at_x)) ? at_x + 16'd1 : at_x - 16'd1;
                run_x = 0;
            end
            if (at_y != goal_y && run_y >= per_y) begin
                coils[3:0] = coil_pattern(at_y, goal_y);
                at_y = ($signed(goal_y) > $signed(at_y)) ? at_y + 16'd1 : at_y - 16'd1;
                run_y = 0;
            end
            if (at_x == goal_x && at_y == goal_y) begin
                coils = 8'h00;
                in_motion = 1'b0;
            end
        end
    endtask

    task automatic predict_motion(input logic op, input logic [15:0] tx, input logic [15:0] ty);
        t_motion m;
        m.rejected = 1'b0;
        if (op == OP_MOVE) begin
            if (in_motion) m.rejected = 1'b1;
            else plan_move(tx, ty);
        end else begin
            advance_tick();
        end
        m.x_coils    = coils[7:4];
        m.y_coils    = coils[3:0];
        m.x_position = at_x;
        m.y_position = at_y;
        m.busy_res   = in_motion;
        expected_motion.push_back(m);
    endtask

    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_item(input logic op, input logic [15:0] tx, input logic [15:0] ty);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            move_bus.valid <= 1'b0;
            random_gap();
        end
        move_bus.valid    <= 1'b1;
        move_bus.op       <= op;
        move_bus.target_x <= tx;
        move_bus.target_y <= ty;
        do @(posedge i_clk); while (!move_bus.ready);
        predict_motion(op, tx, ty);
    endtask

    task automatic wait_drained();
        move_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_motion.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_min_period(input logic [15:0] value);
        wait_drained();
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        min_ticks = value;
    endtask

    task automatic tick_until_idle();
        while (in_motion) send_item(OP_TICK, 16'($urandom), 16'($urandom));
    endtask

    task automatic test_idle_behavior();
        send_item(OP_TICK, 16'h0000, 16'h0000);
        send_item(OP_TICK, 16'hFFFF, 16'hFFFF);
        // move onto the current spot stays idle
        send_item(OP_MOVE, 16'h0000, 16'h0000);
        send_item(OP_TICK, 16'h0000, 16'h0000);
    endtask

    task automatic test_axis_extremes();
        write_min_period(16'd1);
        gaps_on = 1'b0;
        rx_calm = 1'b1;
        // below zero, phase taken from a negative position
        send_item(OP_MOVE, 16'hFFEC, 16'h0000);
        send_item(OP_TICK, 16'h0000, 16'h0000);
        // rejected while busy, extreme targets
        send_item(OP_MOVE, 16'h7FFF, 16'h7FFF);
        tick_until_idle();
        send_item(OP_MOVE, 16'hFFEC, 16'd15);
        send_item(OP_MOVE, 16'h8000, 16'h7FFF);
        tick_until_idle();
        send_item(OP_MOVE, 16'h0000, 16'd15);
        send_item(OP_MOVE, 16'h8000, 16'h8000);
        tick_until_idle();
        send_item(OP_MOVE, 16'h0000, 16'h0000);
        tick_until_idle();
    endtask

    task automatic test_period_scaling();
        write_min_period(16'd40);
        send_item(OP_MOVE, 16'd3, 16'h0000);
        tick_until_idle();
        write_min_period(MIN_PERIOD_RST);
        send_item(OP_MOVE, 16'd4, 16'd1);
        tick_until_idle();
        write_min_period(16'd1);
        send_item(OP_MOVE, 16'hFFFE, 16'd1);
        tick_until_idle();
        gaps_on = 1'b1;
        rx_calm = 1'b0;
    endtask

    task automatic test_backpressure();
        send_item(OP_MOVE, 16'd40, at_y);
        hold_left = 300;
        repeat (60) send_item(OP_TICK, 16'h0000, 16'h0000);
        tick_until_idle();
    endtask

    task automatic test_drain_pause();
        send_item(OP_MOVE, 16'd35, at_y);
        repeat (5) send_item(OP_TICK, 16'h0000, 16'h0000);
        wait_drained();
        tick_until_idle();
    endtask

    task automatic random_phase(input logic [15:0] floor_ticks, input int count);
        int d, e;
        write_min_period(floor_ticks);
        rx_calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++) begin
            if (!in_motion && $urandom_range(0, 9) < 6) begin
                d = (floor_ticks > 16'd10) ? 2 : 20;
                e = $urandom_range(0, d * 2) - d;
                if ($urandom_range(0, 1) == 1) begin
                    send_item(OP_MOVE, at_x + 16'(e), at_y);
                end else begin
                    send_item(OP_MOVE, at_x, at_y + 16'(e));
                end
            end else if (in_motion && $urandom_range(0, 29) == 0) begin
                send_item(OP_MOVE, 16'($urandom), 16'($urandom));
            end else begin
                send_item(OP_TICK, 16'($urandom), 16'($urandom));
            end
        end
        tick_until_idle();
    endtask

    task automatic test_random();
        random_phase(16'd1, 150);
        random_phase(16'd60, 80);
        random_phase(16'($urandom_range(2, 200)), 80);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            res_bus.ready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            res_bus.ready <= 1'b0;
            stall_left--;
        end else if (!rx_calm && $urandom_range(0, 7) == 0) begin
            res_bus.ready <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
        end else begin
            res_bus.ready <= 1'b1;
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_motion m;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (expected_motion.size() == 0) begin
                flag_mismatch("result beat with nothing expected");
            end else begin
                m = expected_motion.pop_front();
                if (res_bus.x_coils !== m.x_coils)
                    flag_mismatch($sformatf("x_coils %h, want %h", res_bus.x_coils, m.x_coils));
                if (res_bus.y_coils !== m.y_coils)
                    flag_mismatch($sformatf("y_coils %h, want %h", res_bus.y_coils, m.y_coils));
                if (res_bus.x_position !== m.x_position)
                    flag_mismatch($sformatf("x_position %h, want %h",
                                            res_bus.x_position, m.x_position));
                if (res_bus.y_position !== m.y_position)
                    flag_mismatch($sformatf("y_position %h, want %h",
                                            res_bus.y_position, m.y_position));
                if (res_bus.busy_res !== m.busy_res)
                    flag_mismatch($sformatf("busy_res %b, want %b", res_bus.busy_res, m.busy_res));
                if (res_bus.rejected !== m.rejected)
                    flag_mismatch($sformatf("rejected %b, want %b", res_bus.rejected, m.rejected));
            end
        end
    end

    initial begin
        error_count = 0;
        gaps_on     = 1'b1;
        rx_calm     = 1'b0;
        hold_left   = 0;
        stall_left  = 0;
        min_ticks   = MIN_PERIOD_RST;
        at_x = 0; at_y = 0; goal_x = 0; goal_y = 0;
        per_x = 0; per_y = 0; run_x = 0; run_y = 0;
        coils = 8'h00;
        in_motion = 1'b0;
        i_rst_n           <= 1'b0;
        move_bus.valid    <= 1'b0;
        move_bus.op       <= OP_TICK;
        move_bus.target_x <= 16'h0000;
        move_bus.target_y <= 16'h0000;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.data      <= 16'h0000;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_behavior();
        test_axis_extremes();
        test_period_scaling();
        test_backpressure();
        test_drain_pause();
        test_random();

        wait_drained();
        repeat (400) @(posedge i_clk);
        if (error_count == 0 && expected_motion.size() == 0) begin
            $display("two_axis_stepper_line_mover_test passed");
        end else begin
            if (expected_motion.size() != 0) flag_mismatch("results still outstanding");
            $display("two_axis_stepper_line_mover_test failed");
        end
        $finish;
    end

endmodule
